// ----- design/qdwc_pkg.sv -----
// Package: shared types, register indexes and constants for the depthwise conv MAC.
package qdwc_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    REG_INPUT_ZP   = 3'd0,
    REG_FILTER_ZP  = 3'd1,
    REG_MULTIPLIER = 3'd2,
    REG_SHIFT      = 3'd3,
    REG_OUTPUT_ZP  = 3'd4,
    REG_CLAMP_LOW  = 3'd5,
    REG_CLAMP_HIGH = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic        [7:0]  input_zp;
    logic        [7:0]  filter_zp;
    logic signed [31:0] multiplier;
    logic        [4:0]  shift;
    logic        [7:0]  output_zp;
    logic        [7:0]  clamp_low;
    logic        [7:0]  clamp_high;
  } cfg_t;

  typedef struct packed {
    logic signed [16:0] prod;
    logic signed [31:0] bias;
    logic               first;
    logic               last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

// ----- design/qdwc_front.sv -----
// Front end: removes zero points, forms the tap product and packs the item.
module qdwc_front
  import qdwc_pkg::*;
(
  input  cfg_t               cfg_i,
  input  logic        [7:0]  sample_i,
  input  logic        [7:0]  tap_i,
  input  logic signed [31:0] bias_i,
  input  logic               first_i,
  input  logic               last_i,
  output item_t              item_o
);

  logic signed [8:0]  a;
  logic signed [8:0]  b;
  logic signed [17:0] prod_full;

  always_comb begin
    a         = $signed({1'b0, sample_i}) - $signed({1'b0, cfg_i.input_zp});
    b         = $signed({1'b0, tap_i}) - $signed({1'b0, cfg_i.filter_zp});
    prod_full = a * b;
    item_o.prod  = prod_full[16:0];
    item_o.bias  = bias_i;
    item_o.first = first_i;
    item_o.last  = last_i;
  end

endmodule

// ----- design/qdwc_queue.sv -----
// Short item queue between the front end and the accumulate/requantize back end.
module qdwc_queue
  import qdwc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_en_i,
  input  item_t   wr_item_i,
  output logic    full_o,
  input  logic    rd_en_i,
  output q_head_t head_o
);

  item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_wr;
  logic                 do_rd;

  always_comb begin
    full_o       = (cnt_q == QueueCntW'(QueueDepth));
    head_o.valid = (cnt_q != '0);
    head_o.item  = mem_q[rd_ptr_q];
    do_wr        = wr_en_i && !full_o;
    do_rd        = rd_en_i && head_o.valid;
    wr_ptr_d     = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d     = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d        = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

// ----- design/qdwc_back.sv -----
// Back end: accumulator and the five-stage requantize pipeline with result register.
module qdwc_back
  import qdwc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  q_head_t    head_i,
  output logic       rd_en_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] result_byte_o
);

  logic signed [31:0] acc_q, acc_d;

  logic               v0_q, v1_q, v2_q, v3_q, v4_q;
  logic               r0, r1, r2, r3, r4;
  logic signed [31:0] s0_acc_q;
  logic signed [63:0] s1_p_q;
  logic signed [31:0] s2_h_q;
  logic signed [15:0] s3_v_q;
  logic        [7:0]  s4_byte_q;

  logic signed [63:0] p_d;
  logic signed [63:0] t;
  logic signed [32:0] h_wide;
  logic signed [31:0] h_d;
  logic signed [32:0] rnd;
  logic signed [32:0] rsum;
  logic signed [32:0] shifted;
  logic signed [15:0] v16_d;
  logic signed [17:0] w;
  logic        [7:0]  byte_sat;
  logic        [7:0]  byte_d;

  always_comb begin
    r4 = !v4_q || pop;
    r3 = !v3_q || r4;
    r2 = !v2_q || r3;
    r1 = !v1_q || r2;
    r0 = !v0_q || r1;

    rd_en_o = head_i.valid && (!head_i.item.last || r0);
    acc_d   = (head_i.item.first ? head_i.item.bias : acc_q)
              + 32'(head_i.item.prod);

    p_d = s0_acc_q * cfg_i.multiplier;

    // rounding doubling high multiply
    t      = s1_p_q + 64'sd1073741824;
    h_wide = t[63:31];
    if (h_wide[32] != h_wide[31]) begin
      h_d = h_wide[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      h_d = h_wide[31:0];
    end

    // rounding right shift, ties up
    rnd     = (cfg_i.shift == 5'd0) ? 33'sd0 : 33'sd1 <<< (cfg_i.shift - 5'd1);
    rsum    = {s2_h_q[31], s2_h_q} + rnd;
    shifted = rsum >>> cfg_i.shift;
    if (shifted > 33'sd32767) begin
      v16_d = 16'sh7fff;
    end else if (shifted < -33'sd32768) begin
      v16_d = 16'sh8000;
    end else begin
      v16_d = shifted[15:0];
    end

    w = 18'(s3_v_q) + $signed({10'd0, cfg_i.output_zp});
    if (w < 18'sd0) begin
      byte_sat = 8'd0;
    end else if (w > 18'sd255) begin
      byte_sat = 8'd255;
    end else begin
      byte_sat = w[7:0];
    end
    byte_d = byte_sat;
    if (byte_d < cfg_i.clamp_low) begin
      byte_d = cfg_i.clamp_low;
    end
    if (byte_d > cfg_i.clamp_high) begin
      byte_d = cfg_i.clamp_high;
    end

    empty         = !v4_q;
    result_byte_o = s4_byte_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
    end else begin
      if (rd_en_o) begin
        acc_q <= acc_d;
      end
      if (r0) begin
        v0_q <= rd_en_o && head_i.item.last;
      end
      if (r1) begin
        v1_q <= v0_q;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
      if (r3) begin
        v3_q <= v2_q;
      end
      if (r4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r0 && rd_en_o && head_i.item.last) begin
      s0_acc_q <= acc_d;
    end
    if (r1 && v0_q) begin
      s1_p_q <= p_d;
    end
    if (r2 && v1_q) begin
      s2_h_q <= h_d;
    end
    if (r3 && v2_q) begin
      s3_v_q <= v16_d;
    end
    if (r4 && v3_q) begin
      s4_byte_q <= byte_d;
    end
  end

endmodule

// ----- design/quantized_depthwise_conv_mac.sv -----
// Top level: config registers, front end, item queue and requantizing back end.
//
// Usage: each item brings one sample, one filter tap, the channel bias and the
// first/last marks of an output window. Items go in on push/full and are taken
// at any edge where push is high and full is low. The front end subtracts the
// zero points and forms the tap product, then the item waits in a four-deep
// queue. The back end takes one item per cycle from the queue into the 32-bit
// wrapping accumulator, but an item marked last waits at the queue head while
// the pipeline cannot take it. It yields one result byte after the requantize
// pipeline (high multiply, rounding shift, saturate, clamp); the byte is on
// result_byte_o while empty is low and leaves at an edge with pop high. The
// item passes the queue and back-end stages s0 to s4, registered around the
// 32x32 multiplier, before empty falls. With pop low the pipeline fills, last
// items back up the queue and full rises. The user must write registers on
// the cfg channel (always ready) only while the block is idle, unchecked by
// the block. Reset clears accumulator, queue, pipeline, registers to defaults.
module quantized_depthwise_conv_mac
  import qdwc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  sample_i,
  input  logic [7:0]  tap_i,
  input  logic [31:0] bias_i,
  input  logic        first_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  result_byte_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t    cfg_q;
  item_t   front_item;
  q_head_t head;
  logic    rd_en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_zp   <= 8'd0;
      cfg_q.filter_zp  <= 8'd0;
      cfg_q.multiplier <= 32'sh40000000;
      cfg_q.shift      <= 5'd0;
      cfg_q.output_zp  <= 8'd0;
      cfg_q.clamp_low  <= 8'd0;
      cfg_q.clamp_high <= 8'd255;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_INPUT_ZP:   cfg_q.input_zp   <= cfg_data_i[7:0];
        REG_FILTER_ZP:  cfg_q.filter_zp  <= cfg_data_i[7:0];
        REG_MULTIPLIER: cfg_q.multiplier <= $signed(cfg_data_i);
        REG_SHIFT:      cfg_q.shift      <= cfg_data_i[4:0];
        REG_OUTPUT_ZP:  cfg_q.output_zp  <= cfg_data_i[7:0];
        REG_CLAMP_LOW:  cfg_q.clamp_low  <= cfg_data_i[7:0];
        REG_CLAMP_HIGH: cfg_q.clamp_high <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  qdwc_front u_front (
    .cfg_i    (cfg_q),
    .sample_i (sample_i),
    .tap_i    (tap_i),
    .bias_i   ($signed(bias_i)),
    .first_i  (first_i),
    .last_i   (last_i),
    .item_o   (front_item)
  );

  qdwc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_item_i (front_item),
    .full_o    (full),
    .rd_en_i   (rd_en),
    .head_o    (head)
  );

  qdwc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (head),
    .rd_en_o       (rd_en),
    .empty         (empty),
    .pop           (pop),
    .result_byte_o (result_byte_o)
  );

endmodule
